### hw/rtl/fpsp_pkg.sv
`default_nettype none
package fpsp_pkg;

  // width of every coordinate field on the ports
  localparam int OUT_BITS = 24;
  // scratch width for widening coordinates before a part-select
  localparam int EXT_BITS = 56;
  // at most this many path points leave per run
  localparam int RES_LIMIT = 64;
  localparam int RES_CNT_BITS = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_FETCH,
    ST_LOAD,
    ST_AREA,
    ST_WAIT,
    ST_DECIDE,
    ST_LOOP,
    ST_GOAL
  } walk_state_t;

  // which funnel test is in flight
  typedef enum logic [1:0] {
    CK_R1,
    CK_R2,
    CK_L1,
    CK_L2
  } check_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } area_res_t;

endpackage
`default_nettype wire

### hw/rtl/funnel_path_string_pull_top.sv
`default_nettype none
// funnel string pulling over a run of portals. push one portal per transaction
// (left and right endpoints, Q15.8); the first portal is the start point and
// the one with last_portal set is the goal, each given with left equal to
// right. while full is low non-goal portals load one per cycle into the
// portal memory and give no result; once MAX_PORTALS-1 are held further
// non-goal portals are dropped and every point of that run reports overflow.
// the goal transaction hands the run to the walker, and full stays high until
// the whole path has been queued. the walker emits start, each funnel corner
// and the goal (last_point set), at most 64 points per run. each portal visit
// passes the loop check, memory read and load, then two to four area tests in
// the three-stage shared area unit; a funnel restart revisits portals after
// the new apex, and the walker stalls while the result queue is full.
module funnel_path_string_pull_top #(
  parameter int MAX_PORTALS = 32,
  parameter int COORD_BITS  = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [23:0] left_x,
  input  wire logic signed [23:0] left_y,
  input  wire logic signed [23:0] left_z,
  input  wire logic signed [23:0] right_x,
  input  wire logic signed [23:0] right_y,
  input  wire logic signed [23:0] right_z,
  input  wire logic               last_portal,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [23:0]      point_x,
  output logic signed [23:0]      point_y,
  output logic signed [23:0]      point_z,
  output logic                    last_point,
  output logic                    overflow
);

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_PORTALS);
  localparam int CW = $clog2(MAX_PORTALS + 1);
  localparam int DW = CW + 1 + 6 * CB;
  localparam int RW = 3 * 24 + 2;

  // front to memory
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [3*CB-1:0] wr_left;
  logic [3*CB-1:0] wr_right;
  logic [AW-1:0]   rd_addr;
  logic [3*CB-1:0] rd_left;
  logic [3*CB-1:0] rd_right;

  // run handoff queue
  logic            desc_push;
  logic            desc_pop;
  logic            desc_full;
  logic            desc_empty;
  logic [CW-1:0]   f_cnt;
  logic            f_ovf;
  logic [3*CB-1:0] f_start;
  logic [3*CB-1:0] f_goal;
  logic [DW-1:0]   desc_head;

  // result queue
  logic            out_push;
  logic            out_full;
  logic [23:0]     b_x;
  logic [23:0]     b_y;
  logic [23:0]     b_z;
  logic            b_last;
  logic            b_ovf;
  logic [RW-1:0]   res_head;

  fpsp_front #(
    .MAX_PORTALS(MAX_PORTALS),
    .CB         (CB)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .left_x      (left_x),
    .left_y      (left_y),
    .left_z      (left_z),
    .right_x     (right_x),
    .right_y     (right_y),
    .right_z     (right_z),
    .last_portal (last_portal),
    .run_busy    (!desc_empty || desc_full),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_left     (wr_left),
    .wr_right    (wr_right),
    .desc_push   (desc_push),
    .desc_cnt    (f_cnt),
    .desc_ovf    (f_ovf),
    .desc_start  (f_start),
    .desc_goal   (f_goal)
  );

  // left and right endpoints live in two memories read at the same index
  fpsp_ram #(
    .W(3 * CB),
    .D(MAX_PORTALS)
  ) u_left_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_left),
    .raddr (rd_addr),
    .rdata (rd_left)
  );

  fpsp_ram #(
    .W(3 * CB),
    .D(MAX_PORTALS)
  ) u_right_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_right),
    .raddr (rd_addr),
    .rdata (rd_right)
  );

  fpsp_fifo #(
    .W(DW)
  ) u_desc_q (
    .clk   (clk),
    .rst   (rst),
    .push  (desc_push),
    .wdata ({f_cnt, f_ovf, f_start, f_goal}),
    .full  (desc_full),
    .pop   (desc_pop),
    .rdata (desc_head),
    .empty (desc_empty)
  );

  fpsp_back #(
    .MAX_PORTALS(MAX_PORTALS),
    .CB         (CB)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_empty (desc_empty),
    .desc_pop   (desc_pop),
    .desc_cnt   (desc_head[DW-1 -: CW]),
    .desc_ovf   (desc_head[6*CB]),
    .desc_start (desc_head[6*CB-1 -: 3*CB]),
    .desc_goal  (desc_head[3*CB-1:0]),
    .rd_addr    (rd_addr),
    .rd_left    (rd_left),
    .rd_right   (rd_right),
    .out_full   (out_full),
    .out_push   (out_push),
    .out_x      (b_x),
    .out_y      (b_y),
    .out_z      (b_z),
    .out_last   (b_last),
    .out_ovf    (b_ovf)
  );

  // path points wait here until popped
  fpsp_fifo #(
    .W(RW)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata ({b_x, b_y, b_z, b_last, b_ovf}),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign point_x    = res_head[RW-1 -: 24];
  assign point_y    = res_head[RW-25 -: 24];
  assign point_z    = res_head[RW-49 -: 24];
  assign last_point = res_head[1];
  assign overflow   = res_head[0];

endmodule
`default_nettype wire

### hw/rtl/fpsp_ram.sv
`default_nettype none
module fpsp_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/fpsp_fifo.sv
`default_nettype none
module fpsp_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic      [W-1:0] rdata,
  output logic              empty
);

  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wp] <= wdata;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fpsp_area.sv
`default_nettype none
module fpsp_area #(
  parameter int CB = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [CB-1:0]   ax,
  input  wire logic signed [CB-1:0]   az,
  input  wire logic signed [CB-1:0]   bx,
  input  wire logic signed [CB-1:0]   bz,
  input  wire logic signed [CB-1:0]   cx,
  input  wire logic signed [CB-1:0]   cz,
  output fpsp_pkg::area_res_t         res,
  output logic                        done
);

  logic signed [CB:0]      ux;
  logic signed [CB:0]      uz;
  logic signed [CB:0]      vx;
  logic signed [CB:0]      vz;
  logic signed [2*CB+1:0]  p;
  logic signed [2*CB+1:0]  q;
  logic        [2*CB+2:0]  diff;
  logic        [2:0]       v;

  assign diff = {p[2*CB+1], p} - {q[2*CB+1], q};
  assign done = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 3'd0;
    end else begin
      v <= {v[1:0], start};
    end
  end

  // edge vectors, then the two cross terms, then the sign and zero flags
  always_ff @(posedge clk) begin
    if (start) begin
      ux <= {bx[CB-1], bx} - {ax[CB-1], ax};
      uz <= {bz[CB-1], bz} - {az[CB-1], az};
      vx <= {cx[CB-1], cx} - {ax[CB-1], ax};
      vz <= {cz[CB-1], cz} - {az[CB-1], az};
    end
    p        <= vx * uz;
    q        <= ux * vz;
    res.neg  <= diff[2*CB+2];
    res.zero <= (diff == '0);
  end

endmodule
`default_nettype wire

### hw/rtl/fpsp_front.sv
`default_nettype none
module fpsp_front #(
  parameter int MAX_PORTALS = 32,
  parameter int CB          = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [23:0]                  left_x,
  input  wire logic signed [23:0]                  left_y,
  input  wire logic signed [23:0]                  left_z,
  input  wire logic signed [23:0]                  right_x,
  input  wire logic signed [23:0]                  right_y,
  input  wire logic signed [23:0]                  right_z,
  input  wire logic                                last_portal,
  input  wire logic                                run_busy,
  output logic                                     wr_en,
  output logic [$clog2(MAX_PORTALS)-1:0]           wr_addr,
  output logic [3*CB-1:0]                          wr_left,
  output logic [3*CB-1:0]                          wr_right,
  output logic                                     desc_push,
  output logic [$clog2(MAX_PORTALS+1)-1:0]         desc_cnt,
  output logic                                     desc_ovf,
  output logic [3*CB-1:0]                          desc_start,
  output logic [3*CB-1:0]                          desc_goal
);

  localparam int AW  = $clog2(MAX_PORTALS);
  localparam int CW  = $clog2(MAX_PORTALS + 1);
  localparam int EXT = fpsp_pkg::EXT_BITS;
  localparam int PAD = EXT - fpsp_pkg::OUT_BITS;

  logic [EXT-1:0]  lx_e;
  logic [EXT-1:0]  ly_e;
  logic [EXT-1:0]  lz_e;
  logic [EXT-1:0]  rx_e;
  logic [EXT-1:0]  ry_e;
  logic [EXT-1:0]  rz_e;
  logic [3*CB-1:0] lcoords;
  logic [3*CB-1:0] start;
  logic [AW-1:0]   pc;
  logic            ovf;
  logic            accept;
  logic            drop;

  // fields are taken as zero-extended then cut to the coordinate width
  assign lx_e = {{PAD{1'b0}}, left_x};
  assign ly_e = {{PAD{1'b0}}, left_y};
  assign lz_e = {{PAD{1'b0}}, left_z};
  assign rx_e = {{PAD{1'b0}}, right_x};
  assign ry_e = {{PAD{1'b0}}, right_y};
  assign rz_e = {{PAD{1'b0}}, right_z};

  assign lcoords  = {lz_e[CB-1:0], ly_e[CB-1:0], lx_e[CB-1:0]};
  assign wr_left  = lcoords;
  assign wr_right = {rz_e[CB-1:0], ry_e[CB-1:0], rx_e[CB-1:0]};

  assign full    = run_busy;
  assign accept  = push && !full;
  assign drop    = accept && !last_portal && (pc == AW'(MAX_PORTALS - 1));
  assign wr_en   = accept && !drop;
  assign wr_addr = pc;

  assign desc_push  = accept && last_portal;
  assign desc_cnt   = CW'(pc) + CW'(1);
  assign desc_ovf   = ovf;
  assign desc_start = (pc == '0) ? lcoords : start;
  assign desc_goal  = lcoords;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      if (last_portal) begin
        pc  <= '0;
        ovf <= 1'b0;
      end else if (drop) begin
        ovf <= 1'b1;
      end else begin
        pc <= pc + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (pc == '0)) begin
      start <= lcoords;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fpsp_back.sv
`default_nettype none
module fpsp_back #(
  parameter int MAX_PORTALS = 32,
  parameter int CB          = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          desc_empty,
  output logic                               desc_pop,
  input  wire logic [$clog2(MAX_PORTALS+1)-1:0] desc_cnt,
  input  wire logic                          desc_ovf,
  input  wire logic [3*CB-1:0]               desc_start,
  input  wire logic [3*CB-1:0]               desc_goal,
  output logic [$clog2(MAX_PORTALS)-1:0]     rd_addr,
  input  wire logic [3*CB-1:0]               rd_left,
  input  wire logic [3*CB-1:0]               rd_right,
  input  wire logic                          out_full,
  output logic                               out_push,
  output logic [23:0]                        out_x,
  output logic [23:0]                        out_y,
  output logic [23:0]                        out_z,
  output logic                               out_last,
  output logic                               out_ovf
);

  localparam int AW  = $clog2(MAX_PORTALS);
  localparam int CW  = $clog2(MAX_PORTALS + 1);
  localparam int EXT = fpsp_pkg::EXT_BITS;
  localparam int NB  = fpsp_pkg::RES_CNT_BITS;

  fpsp_pkg::walk_state_t state;
  fpsp_pkg::walk_state_t state_next;
  fpsp_pkg::check_t      ck;
  fpsp_pkg::area_res_t   sgn;
  fpsp_pkg::area_res_t   area_res;

  logic [3*CB-1:0] apex;
  logic [3*CB-1:0] lft;
  logic [3*CB-1:0] rgt;
  logic [3*CB-1:0] pl;
  logic [3*CB-1:0] pr;
  logic [AW-1:0]   apos;
  logic [AW-1:0]   lpos;
  logic [AW-1:0]   rpos;
  logic [CW-1:0]   i;
  logic [NB-1:0]   n;

  logic            area_start;
  logic            area_done;
  logic [3*CB-1:0] opb;
  logic [3*CB-1:0] opc;
  logic            le0;
  logic            lt0;
  logic            same_ar;
  logic            same_al;
  logic            emit_left;
  logic            emit_right;
  logic            put_req;
  logic            put_ok;
  logic [3*CB-1:0] put_pt;
  logic [EXT-1:0]  ex;
  logic [EXT-1:0]  ey;
  logic [EXT-1:0]  ez;

  assign le0     = sgn.neg || sgn.zero;
  assign lt0     = sgn.neg;
  assign same_ar = (apex[CB-1:0] == rgt[CB-1:0]) && (apex[3*CB-1:2*CB] == rgt[3*CB-1:2*CB]);
  assign same_al = (apex[CB-1:0] == lft[CB-1:0]) && (apex[3*CB-1:2*CB] == lft[3*CB-1:2*CB]);

  assign emit_left  = (state == fpsp_pkg::ST_DECIDE) && (ck == fpsp_pkg::CK_R2) && le0;
  assign emit_right = (state == fpsp_pkg::ST_DECIDE) && (ck == fpsp_pkg::CK_L2) && !lt0;
  assign put_ok     = (n >= NB'(fpsp_pkg::RES_LIMIT)) || !out_full;

  assign opb = ((ck == fpsp_pkg::CK_R1) || (ck == fpsp_pkg::CK_L2)) ? rgt : lft;
  assign opc = ((ck == fpsp_pkg::CK_R1) || (ck == fpsp_pkg::CK_R2)) ? pr : pl;

  fpsp_area #(
    .CB(CB)
  ) u_area (
    .clk   (clk),
    .rst   (rst),
    .start (area_start),
    .ax    (apex[CB-1:0]),
    .az    (apex[3*CB-1:2*CB]),
    .bx    (opb[CB-1:0]),
    .bz    (opb[3*CB-1:2*CB]),
    .cx    (opc[CB-1:0]),
    .cz    (opc[3*CB-1:2*CB]),
    .res   (area_res),
    .done  (area_done)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpsp_pkg::ST_IDLE: begin
        if (!desc_empty) state_next = fpsp_pkg::ST_START;
      end
      fpsp_pkg::ST_START: begin
        if (put_ok) begin
          state_next = (desc_cnt < CW'(2)) ? fpsp_pkg::ST_GOAL : fpsp_pkg::ST_LOOP;
        end
      end
      fpsp_pkg::ST_FETCH:  state_next = fpsp_pkg::ST_LOAD;
      fpsp_pkg::ST_LOAD:   state_next = fpsp_pkg::ST_AREA;
      fpsp_pkg::ST_AREA:   state_next = fpsp_pkg::ST_WAIT;
      fpsp_pkg::ST_WAIT: begin
        if (area_done) state_next = fpsp_pkg::ST_DECIDE;
      end
      fpsp_pkg::ST_DECIDE: begin
        unique case (ck)
          fpsp_pkg::CK_R1: state_next = fpsp_pkg::ST_AREA;
          fpsp_pkg::CK_R2: begin
            if (!le0) state_next = fpsp_pkg::ST_AREA;
            else if (put_ok) state_next = fpsp_pkg::ST_LOOP;
          end
          fpsp_pkg::CK_L1: begin
            state_next = (!lt0 && !same_al) ? fpsp_pkg::ST_AREA : fpsp_pkg::ST_LOOP;
          end
          fpsp_pkg::CK_L2: begin
            if (lt0 || put_ok) state_next = fpsp_pkg::ST_LOOP;
          end
          default: state_next = fpsp_pkg::ST_LOOP;
        endcase
      end
      fpsp_pkg::ST_LOOP: begin
        state_next = (i < desc_cnt) ? fpsp_pkg::ST_FETCH : fpsp_pkg::ST_GOAL;
      end
      fpsp_pkg::ST_GOAL: begin
        if (put_ok) state_next = fpsp_pkg::ST_IDLE;
      end
      default: state_next = fpsp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    area_start = 1'b0;
    desc_pop   = 1'b0;
    put_req    = 1'b0;
    put_pt     = desc_goal;
    out_last   = 1'b0;
    rd_addr    = i[AW-1:0];
    priority case (1'b1)
      state == fpsp_pkg::ST_START: begin
        put_req = 1'b1;
        put_pt  = desc_start;
      end
      state == fpsp_pkg::ST_GOAL: begin
        put_req  = 1'b1;
        out_last = 1'b1;
        desc_pop = put_ok;
      end
      emit_left: begin
        put_req = 1'b1;
        put_pt  = lft;
      end
      emit_right: begin
        put_req = 1'b1;
        put_pt  = rgt;
      end
      state == fpsp_pkg::ST_AREA: area_start = 1'b1;
      default: put_req = 1'b0;
    endcase
  end

  assign out_push = put_req && !out_full && (n < NB'(fpsp_pkg::RES_LIMIT));
  assign out_ovf  = desc_ovf;
  assign ex       = {{(EXT-CB){put_pt[CB-1]}}, put_pt[CB-1:0]};
  assign ey       = {{(EXT-CB){put_pt[2*CB-1]}}, put_pt[2*CB-1:CB]};
  assign ez       = {{(EXT-CB){put_pt[3*CB-1]}}, put_pt[3*CB-1:2*CB]};
  assign out_x    = ex[23:0];
  assign out_y    = ey[23:0];
  assign out_z    = ez[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpsp_pkg::ST_IDLE;
      n     <= '0;
    end else begin
      state <= state_next;
      if ((state == fpsp_pkg::ST_GOAL) && put_ok) begin
        n <= '0;
      end else if (out_push) begin
        n <= n + NB'(1);
      end
    end
  end

  // funnel datapath
  always_ff @(posedge clk) begin
    unique case (state)
      fpsp_pkg::ST_START: begin
        apex <= desc_start;
        lft  <= desc_start;
        rgt  <= desc_start;
        apos <= '0;
        lpos <= '0;
        rpos <= '0;
        i    <= CW'(1);
      end
      fpsp_pkg::ST_LOAD: begin
        ck <= fpsp_pkg::CK_R1;
        if (i == desc_cnt - CW'(1)) begin
          pl <= desc_goal;
          pr <= desc_goal;
        end else begin
          pl <= rd_left;
          pr <= rd_right;
        end
      end
      fpsp_pkg::ST_WAIT: begin
        if (area_done) sgn <= area_res;
      end
      fpsp_pkg::ST_DECIDE: begin
        unique case (ck)
          fpsp_pkg::CK_R1: begin
            if (le0 && !same_ar) begin
              ck <= fpsp_pkg::CK_R2;
            end else begin
              if (le0) begin
                rgt  <= pr;
                rpos <= i[AW-1:0];
              end
              ck <= fpsp_pkg::CK_L1;
            end
          end
          fpsp_pkg::CK_R2: begin
            if (!le0) begin
              rgt  <= pr;
              rpos <= i[AW-1:0];
              ck   <= fpsp_pkg::CK_L1;
            end else if (put_ok) begin
              // right side crossed over left: left corner becomes the apex
              apex <= lft;
              apos <= lpos;
              rgt  <= lft;
              rpos <= lpos;
              i    <= CW'(lpos) + CW'(1);
            end
          end
          fpsp_pkg::CK_L1: begin
            if (!lt0 && !same_al) begin
              ck <= fpsp_pkg::CK_L2;
            end else begin
              if (!lt0) begin
                lft  <= pl;
                lpos <= i[AW-1:0];
              end
              i <= i + CW'(1);
            end
          end
          fpsp_pkg::CK_L2: begin
            if (lt0) begin
              lft  <= pl;
              lpos <= i[AW-1:0];
              i    <= i + CW'(1);
            end else if (put_ok) begin
              // left side crossed over right: right corner becomes the apex
              apex <= rgt;
              apos <= rpos;
              lft  <= rgt;
              lpos <= rpos;
              i    <= CW'(rpos) + CW'(1);
            end
          end
          default: ck <= fpsp_pkg::CK_R1;
        endcase
      end
      default: begin
        apos <= apos;
      end
    endcase
  end

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
// self-checking bench for the funnel string puller: portals are pushed one per
// transaction, a local funnel model predicts the path of every run, and a
// monitor compares each popped point against the oldest predicted point
module tb;
  localparam int PORTAL_CAP = 32;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               last;
    logic               ovf;
  } path_point_t;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } vec3_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [23:0] left_x = '0, left_y = '0, left_z = '0;
  logic signed [23:0] right_x = '0, right_y = '0, right_z = '0;
  logic last_portal = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [23:0] point_x, point_y, point_z;
  logic last_point, overflow;

  // predictor state: the run being loaded
  vec3_t       run_pts[2*PORTAL_CAP];
  int          run_len = 0;
  logic        run_ovf = 1'b0;
  path_point_t expected_points[$];

  int  errors = 0;
  int  points_seen = 0;
  int  runs_sent = 0;
  int  cycles = 0;
  bit  send_gaps = 1'b1;
  bit  pop_gaps = 1'b1;
  bit  hold_pops = 1'b0;
  int  hold_cycles = 0;
  bit  stall_pops = 1'b0;

  funnel_path_string_pull_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .left_x(left_x), .left_y(left_y), .left_z(left_z),
    .right_x(right_x), .right_y(right_y), .right_z(right_z),
    .last_portal(last_portal), .empty(empty), .pop(pop),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .last_point(last_point), .overflow(overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // sign of the x/z cross product (c-a) x (b-a); exact in 64-bit
  function automatic int xz_turn(vec3_t a, vec3_t b, vec3_t c);
    longint ax, az, bx, bz, d;
    ax = longint'(b.x) - longint'(a.x);
    az = longint'(b.z) - longint'(a.z);
    bx = longint'(c.x) - longint'(a.x);
    bz = longint'(c.z) - longint'(a.z);
    d = bx * az - ax * bz;
    return (d < 0) ? -1 : ((d > 0) ? 1 : 0);
  endfunction

  function automatic bit same_plane_pt(vec3_t a, vec3_t b);
    return a.x == b.x && a.z == b.z;
  endfunction

  function automatic void queue_point(vec3_t p, logic last, ref int n);
    path_point_t e;
    if (n >= 64) return;
    e.x = p.x; e.y = p.y; e.z = p.z; e.last = last; e.ovf = run_ovf;
    expected_points.push_back(e);
    n++;
  endfunction

  // funnel walk over the loaded run, queues every predicted path point
  function automatic void predict_path();
    vec3_t start, goal, apex, lft, rgt, pl, pr;
    int apex_i, lft_i, rgt_i, i, n;
    bit restart;
    n = 0;
    start = run_pts[0];
    goal = run_pts[2*(run_len-1)];
    queue_point(start, 1'b0, n);
    if (run_len >= 2) begin
      apex = start; lft = start; rgt = start;
      apex_i = 0; lft_i = 0; rgt_i = 0;
      i = 1;
      while (i < run_len) begin
        restart = 1'b0;
        if (i == run_len - 1) begin
          pl = goal; pr = goal;
        end else begin
          pl = run_pts[2*i]; pr = run_pts[2*i+1];
        end
        if (xz_turn(apex, rgt, pr) <= 0) begin
          if (same_plane_pt(apex, rgt) || xz_turn(apex, lft, pr) > 0) begin
            rgt = pr; rgt_i = i;
          end else begin
            // right side crossed the left edge: left corner becomes apex
            queue_point(lft, 1'b0, n);
            apex = lft; apex_i = lft_i; rgt = apex; rgt_i = apex_i;
            i = apex_i + 1;
            restart = 1'b1;
          end
        end
        if (!restart && xz_turn(apex, lft, pl) >= 0) begin
          if (same_plane_pt(apex, lft) || xz_turn(apex, rgt, pl) < 0) begin
            lft = pl; lft_i = i;
          end else begin
            queue_point(rgt, 1'b0, n);
            apex = rgt; apex_i = rgt_i; lft = apex; lft_i = apex_i;
            i = apex_i + 1;
            restart = 1'b1;
          end
        end
        if (!restart) i++;
      end
    end
    queue_point(goal, 1'b1, n);
  endfunction

  // model update for one accepted portal
  function automatic void load_portal(vec3_t l, vec3_t r, logic is_goal);
    if (!is_goal && run_len >= PORTAL_CAP - 1) begin
      run_ovf = 1'b1;
      return;
    end
    run_pts[2*run_len] = l;
    run_pts[2*run_len+1] = r;
    run_len++;
    if (is_goal) begin
      predict_path();
      run_len = 0;
      run_ovf = 1'b0;
      runs_sent++;
    end
  endfunction

  // one push transaction, with an optional random gap first; push stays high
  // afterwards so back-to-back sends leave no gap between them
  task automatic send_portal(vec3_t l, vec3_t r, logic is_goal);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    push <= 1'b1;
    left_x <= l.x; left_y <= l.y; left_z <= l.z;
    right_x <= r.x; right_y <= r.y; right_z <= r.z;
    last_portal <= is_goal;
    do @(posedge clk); while (full);
    load_portal(l, r, is_goal);
  endtask

  function automatic vec3_t rand_pt(int span);
    vec3_t p;
    if (span == 0) begin
      p.x = $urandom; p.y = $urandom; p.z = $urandom;
    end else begin
      p.x = $urandom_range(0, 2*span) - span;
      p.y = $urandom;
      p.z = $urandom_range(0, 2*span) - span;
    end
    return p;
  endfunction

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  // long receiver hold-off, counted here on its own
  task automatic long_hold(int hold_len);
    stall_pops = 1'b1;
    repeat (hold_len) @(posedge clk);
    stall_pops = 1'b0;
  endtask

  // a corridor going roughly forward in z with jitter, so corners appear, or fully random points when wild
  task automatic send_corridor(int portals, int span, bit wild);
    vec3_t l, r, s;
    int k;
    s = wild ? rand_pt(0) : rand_pt(span);
    send_portal(s, s, portals == 1);
    for (k = 1; k < portals - 1; k++) begin
      if (wild) begin
        l = rand_pt(0); r = rand_pt(0);
      end else begin
        l = rand_pt(span); r = rand_pt(span);
        l.z = k * span + ($urandom_range(0, span) - span/2);
        r.z = l.z;
        l.x = -span + $urandom_range(0, span);
        r.x = $urandom_range(0, span);
      end
      send_portal(l, r, 1'b0);
    end
    if (portals > 1) begin
      s = wild ? rand_pt(0) : rand_pt(span);
      if (!wild) s.z = portals * span;
      send_portal(s, s, 1'b1);
    end
  endtask

  task automatic test_directed();
    vec3_t a, b, c, d;
    // goal as the only portal
    a.x = 24'sh7fffff; a.y = 24'sh800000; a.z = 24'sh7fffff;
    send_portal(a, a, 1'b1);
    // extremes: start at min corner, goal at max corner, full-range portal
    a.x = 24'sh800000; a.y = 24'sh7fffff; a.z = 24'sh800000;
    b.x = 24'sh800000; b.y = 24'sh000000; b.z = 24'sh7fffff;
    c.x = 24'sh7fffff; c.y = 24'shffffff; c.z = 24'sh800000;
    d.x = 24'sh7fffff; d.y = 24'sh555555; d.z = 24'sh7fffff;
    send_portal(a, a, 1'b0);
    send_portal(b, c, 1'b0);
    send_portal(c, b, 1'b0);
    send_portal(d, d, 1'b1);
    // three-portal run, all-zero points (degenerate apex equality)
    a = '{default: '0};
    send_portal(a, a, 1'b0);
    send_portal(a, a, 1'b0);
    send_portal(a, a, 1'b1);
    // zig-zag corridor forcing corners on both sides
    a = '{x: 0, y: 1, z: 0};
    send_portal(a, a, 1'b0);
    b = '{x: -256, y: 2, z: 256}; c = '{x: 256, y: 3, z: 256};
    send_portal(b, c, 1'b0);
    b = '{x: 512, y: 4, z: 512}; c = '{x: 1024, y: 5, z: 512};
    send_portal(b, c, 1'b0);
    b = '{x: -1024, y: 6, z: 768}; c = '{x: -512, y: 7, z: 768};
    send_portal(b, c, 1'b0);
    d = '{x: 0, y: 8, z: 1024};
    send_portal(d, d, 1'b1);
    wait_drained();
  endtask

  // store full: a run with more non-goal portals than capacity, overflow on every point, then a run that fits
  task automatic test_overflow();
    send_corridor(PORTAL_CAP + 4, 2048, 1'b0);
    send_corridor(PORTAL_CAP - 1, 512, 1'b0);
    wait_drained();
  endtask

  // long receiver hold-off while the sender keeps pushing
  task automatic test_backpressure();
    fork
      long_hold(400);
    join_none
    send_corridor(6, 1024, 1'b0);
    send_corridor(5, 1024, 1'b0);
    send_corridor(1, 1024, 1'b0);
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 30) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 8);
      send_corridor(len, $urandom_range(1, 4) * 256, $urandom_range(0, 4) == 0);
      sent += len;
    end
    // final stretch with no idling
    send_gaps = 1'b0;
    pop_gaps = 1'b0;
    send_corridor(6, 768, 1'b0);
    send_corridor(5, 0, 1'b1);
    wait_drained();
  endtask

  // receiver: pops with random bursts of idling, or holds off when asked
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_pops) begin
      pop <= 1'b0;
    end else if (hold_pops) begin
      pop <= 1'b0;
      if (hold_cycles == 0) hold_pops <= 1'b0;
      else hold_cycles <= hold_cycles - 1;
    end else if (pop_gaps && $urandom_range(0, 4) == 0) begin
      pop <= 1'b0;
      hold_cycles <= $urandom_range(1, 7);
      hold_pops <= 1'b1;
    end else begin
      pop <= 1'b1;
    end
  end

  // checker: compares every popped transaction against the oldest prediction
  always @(posedge clk) begin
    path_point_t e;
    if (!rst && pop && !empty) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        $error("unexpected path point x=%0d z=%0d", point_x, point_z);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (point_x !== e.x) begin
          $error("point_x expected %0d got %0d", e.x, point_x); errors++;
        end
        if (point_y !== e.y) begin
          $error("point_y expected %0d got %0d", e.y, point_y); errors++;
        end
        if (point_z !== e.z) begin
          $error("point_z expected %0d got %0d", e.z, point_z); errors++;
        end
        if (last_point !== e.last) begin
          $error("last_point expected %0b got %0b", e.last, last_point); errors++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow expected %0b got %0b", e.ovf, overflow); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("funnel_path_string_pull_top regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    repeat (50) @(posedge clk);
    if (expected_points.size() != 0) begin
      $error("%0d path points never arrived", expected_points.size());
      errors++;
    end
    $display("covered %0d runs and %0d path points, incl. overflow and stalls",
             runs_sent, points_seen);
    if (errors == 0) begin
      $display("funnel_path_string_pull_top regression: pass");
    end else begin
      $display("funnel_path_string_pull_top regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
